[rtl/brbff_pkg.sv]
// Shared types and constants for the byte ring buffer with frame header search.
// Used by the controller, the byte store and the top level. No dependencies.
package brbff_pkg;

  localparam int IDX_W = 8;

  localparam logic [2:0] MODE_PUSH  = 3'd0;
  localparam logic [2:0] MODE_POP   = 3'd1;
  localparam logic [2:0] MODE_FIND  = 3'd2;
  localparam logic [2:0] MODE_FLUSH = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  localparam logic REG_BUF_SIZE = 1'b0;
  localparam logic REG_DATA_W   = 1'b1;

  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hAA;
  localparam logic [3:0] DATA_W7    = 4'd7;
  localparam logic [7:0] MIN_FIND   = 8'd5;
  localparam logic [6:0] FIND_START = 7'd3;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] push_byte;
    logic [6:0] pop_count;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
    logic [7:0] found_offset;
    logic [7:0] fill_level;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

[rtl/brbff_mem.sv]
// Byte store: one write port, one read port, registered read data.
// Depends on brbff_pkg for the request struct.
module brbff_mem import brbff_pkg::*; #(
  parameter int MEM_DEPTH = 256
) (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  localparam int AW = $clog2(MEM_DEPTH);

  logic [7:0] store [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      store[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata <= store[req.raddr[AW-1:0]];
  end

endmodule

[rtl/brbff_ctrl.sv]
// Sequencer: indices, configuration, command decode, pop and header scan walks.
// Depends on brbff_pkg; drives the byte store through a mem_req_t.
module brbff_ctrl import brbff_pkg::*; #(
  parameter int SLOT_LIMIT = 256,
  parameter int MAX_BURST  = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  cmd_t       cmd,
  output logic       busy,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  output mem_req_t   mem_req,
  input  logic [7:0] mem_rdata,
  output logic       strobe,
  output result_t    result
);

  localparam logic [8:0] SLOT_MAX = 9'(SLOT_LIMIT);
  localparam logic [6:0] BURST    = 7'(MAX_BURST);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_POP  = 4'b0010,
    ST_FIND = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] widx, ridx, addr;
  logic [8:0]       slots;
  logic             seven;
  logic [6:0]       rem;
  logic             pv, plast;
  logic             fv, prev55;
  logic [8:0]       k, fk;
  logic [7:0]       len_q;
  logic [7:0]       found;
  logic [7:0]       held_now;
  logic [6:0]       cnt_lim, pop_n;

  function automatic logic [8:0] clamp_slots(input logic [8:0] v);
    if (v < 9'd2) return 9'd2;
    else if (v > SLOT_MAX) return SLOT_MAX;
    else return v;
  endfunction

  function automatic logic [7:0] held(input logic [7:0] w, input logic [7:0] r,
                                      input logic [8:0] s);
    logic [8:0] t;
    t = {1'b0, w} + s - {1'b0, r};
    if (r == w) return 8'd0;
    else if (r < w) return w - r;
    else return t[7:0];
  endfunction

  function automatic logic [7:0] inc(input logic [7:0] v, input logic [8:0] s);
    logic [8:0] t;
    t = {1'b0, v} + 9'd1;
    return (t == s) ? 8'd0 : t[7:0];
  endfunction

  // n stays below s, so one subtract folds the sum back
  function automatic logic [7:0] adv(input logic [7:0] v, input logic [6:0] n,
                                     input logic [8:0] s);
    logic [8:0] t;
    logic [8:0] u;
    t = {1'b0, v} + {2'b00, n};
    u = t - s;
    return (t >= s) ? u[7:0] : t[7:0];
  endfunction

  assign held_now = held(widx, ridx, slots);
  assign cnt_lim  = (cmd.pop_count > BURST) ? BURST : cmd.pop_count;
  assign pop_n    = ({1'b0, held_now} < {2'b00, cnt_lim}) ? held_now[6:0] : cnt_lim;

  // beats still in the read pipe keep busy up
  assign busy = (state != ST_IDLE) || pv;

  always_comb begin
    mem_req.we    = start && !busy && (cmd.mode == MODE_PUSH);
    mem_req.waddr = widx;
    mem_req.wdata = seven ? {1'b0, cmd.push_byte[6:0]} : cmd.push_byte;
    mem_req.raddr = addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      widx   <= '0;
      ridx   <= '0;
      slots  <= SLOT_MAX;
      seven  <= 1'b0;
      strobe <= 1'b0;
      pv     <= 1'b0;
      fv     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      pv     <= 1'b0;
      fv     <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_BUF_SIZE: begin
            slots <= clamp_slots(cfg_data);
            widx  <= '0;
            ridx  <= '0;
          end
          REG_DATA_W: seven <= (cfg_data[3:0] == DATA_W7);
          default: ;
        endcase
      end

      if (pv) begin
        strobe <= 1'b1;
        result <= '{out_byte: mem_rdata, has_byte: 1'b1, out_last: plast,
                    found_offset: 8'd0, fill_level: held_now};
      end

      unique case (state)
        ST_IDLE: begin
          if (start && !busy) begin
            found <= 8'd0;
            state <= ST_FIN;
            priority case (cmd.mode)
              MODE_PUSH: widx <= inc(widx, slots);
              MODE_POP: begin
                if (pop_n != 7'd0) begin
                  addr  <= ridx;
                  rem   <= pop_n;
                  ridx  <= adv(ridx, pop_n, slots);
                  state <= ST_POP;
                end
              end
              MODE_FIND: begin
                if (held_now >= MIN_FIND) begin
                  addr   <= adv(ridx, FIND_START, slots);
                  k      <= {2'b00, FIND_START};
                  len_q  <= held_now;
                  prev55 <= 1'b0;
                  state  <= ST_FIND;
                end
              end
              MODE_FLUSH: ridx <= widx;
              MODE_CLEAR: begin
                widx <= '0;
                ridx <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_POP: begin
          pv    <= 1'b1;
          plast <= (rem == 7'd1);
          addr  <= inc(addr, slots);
          rem   <= rem - 7'd1;
          if (rem == 7'd1) state <= ST_IDLE;
        end
        ST_FIND: begin
          // reads run one ahead; reads past the end are dropped
          fv   <= 1'b1;
          fk   <= k;
          k    <= k + 9'd1;
          addr <= inc(addr, slots);
          if (fv) begin
            prev55 <= (mem_rdata == HDR_FIRST);
            if (prev55 && (mem_rdata == HDR_SECOND)) begin
              found <= 8'(fk - 9'd1);
              state <= ST_FIN;
            end else if (fk == {1'b0, len_q} - 9'd1) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          strobe <= 1'b1;
          result <= '{out_byte: 8'd0, has_byte: 1'b0, out_last: 1'b1,
                      found_offset: found, fill_level: held_now};
          state  <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/byte_ring_buffer_frame_finder.sv]
// Byte ring buffer with header search. Push, flush, clear, empty pop, short find: one
// result, from the FIN state; the next command can be taken while it is shown. Pop of
// n bytes: beats pass the POP state, store read register and result register, one beat
// per cycle (one store read each); the next command can be taken at the edge of the
// last beat. Find: one stored byte read per cycle. Results cannot be stalled.
// Synchronous reset: indices zero, size 256 (capped at DEPTH), 8-bit data; store kept.
module byte_ring_buffer_frame_finder import brbff_pkg::*; #(
  parameter int DEPTH     = 256,
  parameter int MAX_BURST = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  cmd_t       cmd,
  output logic       busy,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  output logic       strobe,
  output result_t    result
);

  localparam int SLOT_LIMIT = (DEPTH < 256) ? DEPTH : 256;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  brbff_ctrl #(
    .SLOT_LIMIT (SLOT_LIMIT),
    .MAX_BURST  (MAX_BURST)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .strobe    (strobe),
    .result    (result)
  );

  brbff_mem #(
    .MEM_DEPTH (SLOT_LIMIT)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

[rtl/brbff_checker.sv]
// Port-level checks for the byte ring buffer, bound to the top level.
// Depends on brbff_pkg for the result struct.
module brbff_checker import brbff_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    strobe,
  input result_t result
);

  // busy rises after every accepted command
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low right after accept");

  // pop beats come back to back
  a_burst_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.out_last |=> strobe && result.has_byte)
    else $error("gap inside pop burst");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.out_last |=> !strobe)
    else $error("beat right after last beat");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.has_byte |-> result.out_last && (result.out_byte == 8'd0))
    else $error("bad beat without byte");

  a_pop_no_offset: assert property (@(posedge clk) disable iff (rst)
    strobe && result.has_byte |-> (result.found_offset == 8'd0))
    else $error("offset on pop beat");

endmodule

bind byte_ring_buffer_frame_finder brbff_checker u_chk (.*);
